/* rtl/isr_pkg.sv */
package isr_pkg;

	localparam int IN_W       = 8;
	localparam int RATIO_W    = 16;
	localparam int FRAC_W     = 15;
	localparam int MAG_W      = 16;
	localparam int DEN_W      = 17;
	localparam int SQ_FRAC    = 16;
	localparam int TH_W       = 14;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam logic [8:0]  EDGE_THRESHOLD_RST  = 9'd35;
	localparam logic [7:0]  MID_WINDOW_LOW_RST  = 8'd36;
	localparam logic [7:0]  MID_WINDOW_HIGH_RST = 8'd75;
	localparam logic [7:0]  OUTER_LOW_RST       = 8'd45;
	localparam logic [14:0] RATIO_LIMIT_RST     = 15'd29491;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_METHOD          = 3'd0,
		REG_EDGE_THRESHOLD  = 3'd1,
		REG_MID_WINDOW_LOW  = 3'd2,
		REG_MID_WINDOW_HIGH = 3'd3,
		REG_OUTER_LOW       = 3'd4,
		REG_RATIO_LIMIT     = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [IN_W-1:0] outer_left;
		logic [IN_W-1:0] inner_left;
		logic [IN_W-1:0] inner_right;
		logic [IN_W-1:0] outer_right;
	} in_item_t;

	typedef struct packed {
		logic signed [RATIO_W-1:0] ratio;
		logic                      used_inner;
		logic                      held;
	} out_item_t;

	typedef struct packed {
		logic acc;
		logic last;
		logic decide;
		logic sq_first;
		logic sq_add;
		logic side;
		logic sqrt_start;
		logic scale_start;
		logic ratio_start;
		logic store_mag;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic method;
		logic hold;
		logic sqrt_done;
		logic scale_done;
		logic div_done;
	} dp_status_t;

endpackage

/* rtl/isr_div.sv */
module isr_div #(
	parameter int NUM_W = 19,
	parameter int DEN_W = 17,
	parameter int CNT_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DEN_W-1:0] rem_init,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [CNT_W-1:0] steps,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quot_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   trial_sub;
	logic             ge;

	// Restoring division: one quotient bit per cycle.
	assign trial     = {rem_q, num_q[NUM_W-1]};
	assign ge        = trial >= {1'b0, den_q};
	assign trial_sub = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			num_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			quot_q <= {quot_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

/* rtl/isr_sqrt.sv */
module isr_sqrt #(
	parameter int IN_W = 38
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [IN_W-1:0]     x,
	output logic                done,
	output logic [IN_W/2-1:0]   root
);

	localparam int ROOT_W = IN_W / 2;
	localparam int RW     = ROOT_W + 2;
	localparam int CNT_W  = $clog2(ROOT_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IN_W-1:0]   x_q;
	logic [RW-1:0]     rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [RW+1:0]     rem2;
	logic [RW+1:0]     trial;
	logic [RW+1:0]     rem_sub;
	logic              ge;

	// Digit-by-digit square root, two radicand bits per cycle.
	assign rem2    = {rem_q, x_q[IN_W-1 -: 2]};
	assign trial   = (RW + 2)'({root_q, 2'b01});
	assign ge      = rem2 >= trial;
	assign rem_sub = rem2 - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[IN_W-3:0], 2'b00};
			rem_q  <= ge ? rem_sub[RW-1:0] : rem2[RW-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* rtl/isr_datapath.sv */
module isr_datapath #(
	parameter int ROUNDS = 3
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  isr_pkg::in_item_t                     in_data,
	input  logic                                  cfg_we,
	input  logic [isr_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [isr_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  isr_pkg::ctrl_cmd_t                    cmd,
	output isr_pkg::dp_status_t                   status,
	output isr_pkg::out_item_t                    out_data
);

	import isr_pkg::*;

	localparam int TOP       = 200 * ROUNDS;
	localparam int BOTTOM    = 2 * ROUNDS;
	localparam int SCALE     = 2 * ROUNDS;
	localparam int SUM_W     = $clog2(TOP + 1);
	localparam int SQ_W      = 2 * SUM_W + 1;
	localparam int X_W       = SQ_W + SQ_FRAC;
	localparam int SQRT_IN_W = X_W + (X_W % 2);
	localparam int ROOT_W    = SQRT_IN_W / 2;
	localparam int DCNT_W    = $clog2(FRAC_W + 1);
	localparam int SC_SHIFT  = ROOT_W + $clog2(SCALE);
	localparam int RECIP_W   = ROOT_W + 2;
	localparam int SC_RECIP  = ((1 << SC_SHIFT) + SCALE - 1) / SCALE;
	localparam int PROD_W    = ROOT_W + RECIP_W;

	logic                 method_q;
	logic [8:0]           edge_threshold_q;
	logic [7:0]           mid_window_low_q;
	logic [7:0]           mid_window_high_q;
	logic [7:0]           outer_low_q;
	logic [14:0]          ratio_limit_q;

	logic [SUM_W-1:0]     sum_q [4];
	logic [SUM_W-1:0]     s_q [4];
	logic [IN_W-1:0]      in_vals [4];
	logic [SUM_W:0]       sum_add [4];
	logic [SUM_W-1:0]     sum_sat [4];
	logic [SUM_W-1:0]     sum_floor [4];

	logic [TH_W-1:0]      outer_sum;
	logic [TH_W-1:0]      inner_sum;
	logic [TH_W-1:0]      total_sum;
	logic                 use_inner;
	logic                 hold;

	logic [SUM_W-1:0]     mul_op;
	logic [2*SUM_W-1:0]   prod;
	logic [SQ_W-1:0]      acc_q;

	logic                 sqrt_done;
	logic [ROOT_W-1:0]    root;

	logic [PROD_W-1:0]    scale_prod;
	logic [MAG_W-1:0]     mag_q;
	logic                 scale_done_q;

	logic [MAG_W-1:0]     a_q;
	logic [MAG_W-1:0]     b_q;
	logic                 neg_q;
	logic                 used_q;
	logic                 held_q;
	logic signed [RATIO_W-1:0] last_q;

	logic                 div_start;
	logic [DEN_W-1:0]     div_rem;
	logic [DEN_W-1:0]     div_den;
	logic                 div_done;
	logic [FRAC_W-1:0]    quot;

	logic                 fin_neg;
	logic [FRAC_W-1:0]    fin_mag;
	logic [FRAC_W-1:0]    clamp_mag;
	logic [RATIO_W-1:0]   last_abs;
	logic [RATIO_W-1:0]   fin_ratio;
	out_item_t            out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q          <= 1'b0;
			edge_threshold_q  <= EDGE_THRESHOLD_RST;
			mid_window_low_q  <= MID_WINDOW_LOW_RST;
			mid_window_high_q <= MID_WINDOW_HIGH_RST;
			outer_low_q       <= OUTER_LOW_RST;
			ratio_limit_q     <= RATIO_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_METHOD:          method_q          <= cfg_data[0];
				REG_EDGE_THRESHOLD:  edge_threshold_q  <= cfg_data[8:0];
				REG_MID_WINDOW_LOW:  mid_window_low_q  <= cfg_data[7:0];
				REG_MID_WINDOW_HIGH: mid_window_high_q <= cfg_data[7:0];
				REG_OUTER_LOW:       outer_low_q       <= cfg_data[7:0];
				REG_RATIO_LIMIT:     ratio_limit_q     <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	assign in_vals[0] = in_data.outer_left;
	assign in_vals[1] = in_data.inner_left;
	assign in_vals[2] = in_data.inner_right;
	assign in_vals[3] = in_data.outer_right;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sum_add[i]   = {1'b0, sum_q[i]} + (SUM_W + 1)'(in_vals[i]);
			sum_sat[i]   = (sum_add[i] > (SUM_W + 1)'(TOP)) ? SUM_W'(TOP)
			                                               : sum_add[i][SUM_W-1:0];
			sum_floor[i] = (sum_sat[i] < SUM_W'(BOTTOM)) ? SUM_W'(BOTTOM) : sum_sat[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				sum_q[i] <= '0;
			end
		end else if (cmd.last) begin
			for (int i = 0; i < 4; i++) begin
				sum_q[i] <= '0;
			end
		end else if (cmd.acc) begin
			for (int i = 0; i < 4; i++) begin
				sum_q[i] <= sum_sat[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.last) begin
			for (int i = 0; i < 4; i++) begin
				s_q[i] <= sum_floor[i];
			end
		end
	end

	// Thresholds are in normalized units, so they are scaled up rather than
	// dividing the sums down.
	assign outer_sum = TH_W'(s_q[0]) + TH_W'(s_q[3]);
	assign inner_sum = TH_W'(s_q[1]) + TH_W'(s_q[2]);
	assign total_sum = outer_sum + inner_sum;
	assign use_inner = ((inner_sum > TH_W'(mid_window_low_q) * TH_W'(SCALE)) &&
	                    (inner_sum < TH_W'(mid_window_high_q) * TH_W'(SCALE))) ||
	                   (outer_sum < TH_W'(outer_low_q) * TH_W'(SCALE));
	assign hold      = total_sum <= TH_W'(edge_threshold_q) * TH_W'(SCALE);

	// Left side squares outer_left then inner_left; right side outer_right
	// then inner_right.
	always_comb begin
		case ({cmd.side, cmd.sq_add})
			2'b00:   mul_op = s_q[0];
			2'b01:   mul_op = s_q[1];
			2'b10:   mul_op = s_q[3];
			default: mul_op = s_q[2];
		endcase
	end

	assign prod = mul_op * mul_op;

	always_ff @(posedge clk) begin
		if (cmd.sq_first) begin
			acc_q <= SQ_W'(prod);
		end else if (cmd.sq_add) begin
			acc_q <= acc_q + SQ_W'(prod);
		end
	end

	isr_sqrt #(
		.IN_W(SQRT_IN_W)
	) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqrt_start),
		.x      (SQRT_IN_W'({acc_q, {SQ_FRAC{1'b0}}})),
		.done   (sqrt_done),
		.root   (root)
	);

	// The level scale is a constant, so each root is divided by it with a
	// reciprocal multiply that is exact over the whole root range.
	assign scale_prod = PROD_W'(root) * PROD_W'(SC_RECIP);

	always_ff @(posedge clk) begin
		if (cmd.scale_start) begin
			mag_q <= scale_prod[SC_SHIFT +: MAG_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_done_q <= 1'b0;
		end else begin
			scale_done_q <= cmd.scale_start;
		end
	end

	assign div_start = cmd.ratio_start;
	assign div_rem   = (a_q >= b_q) ? DEN_W'(a_q - b_q) : DEN_W'(b_q - a_q);
	assign div_den   = DEN_W'(a_q) + DEN_W'(b_q);

	isr_div #(
		.NUM_W (FRAC_W),
		.DEN_W (DEN_W),
		.CNT_W (DCNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem),
		.num      ('0),
		.den      (div_den),
		.steps    (DCNT_W'(FRAC_W)),
		.done     (div_done),
		.quot     (quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			used_q <= ~method_q & use_inner;
			held_q <= method_q & hold;
			if (use_inner) begin
				a_q <= MAG_W'(s_q[1]);
				b_q <= MAG_W'(s_q[2]);
			end else begin
				a_q <= MAG_W'(s_q[0]);
				b_q <= MAG_W'(s_q[3]);
			end
		end else if (cmd.store_mag) begin
			if (cmd.side) begin
				b_q <= mag_q;
			end else begin
				a_q <= mag_q;
			end
		end
		if (cmd.ratio_start) begin
			neg_q <= a_q < b_q;
		end
	end

	// The stored ratio never reaches -32768, so its magnitude fits 15 bits.
	assign last_abs  = last_q[RATIO_W-1] ? RATIO_W'(-last_q) : RATIO_W'(last_q);
	assign fin_neg   = held_q ? last_q[RATIO_W-1] : neg_q;
	assign fin_mag   = held_q ? last_abs[FRAC_W-1:0] : quot;
	assign clamp_mag = (fin_mag > ratio_limit_q) ? ratio_limit_q : fin_mag;
	assign fin_ratio = fin_neg ? (RATIO_W'(0) - {1'b0, clamp_mag}) : {1'b0, clamp_mag};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (cmd.finish) begin
			last_q <= signed'(fin_ratio);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.ratio      <= signed'(fin_ratio);
			out_q.used_inner <= used_q;
			out_q.held       <= held_q;
		end
	end

	assign out_data          = out_q;
	assign status.method     = method_q;
	assign status.hold       = hold;
	assign status.sqrt_done  = sqrt_done;
	assign status.scale_done = scale_done_q;
	assign status.div_done   = div_done;

endmodule

/* rtl/isr_ctrl.sv */
module isr_ctrl #(
	parameter int ROUNDS = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  isr_pkg::dp_status_t status,
	output isr_pkg::ctrl_cmd_t  cmd
);

	import isr_pkg::*;

	localparam int CNT_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

	typedef enum logic [10:0] {
		ST_IDLE       = 11'b000_0000_0001,
		ST_DECIDE     = 11'b000_0000_0010,
		ST_SQ_A       = 11'b000_0000_0100,
		ST_SQ_B       = 11'b000_0000_1000,
		ST_SQRT_GO    = 11'b000_0001_0000,
		ST_SQRT_WAIT  = 11'b000_0010_0000,
		ST_SCALE_GO   = 11'b000_0100_0000,
		ST_SCALE_WAIT = 11'b000_1000_0000,
		ST_RATIO_GO   = 11'b001_0000_0000,
		ST_RATIO_WAIT = 11'b010_0000_0000,
		ST_FINISH     = 11'b100_0000_0000
	} state_t;

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] round_q;
	logic             side_q;
	logic             out_valid_q;
	logic             accept;
	logic             last_round;
	logic             load_out;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid & in_ready;
	assign last_round = (round_q == CNT_W'(ROUNDS - 1));
	assign load_out   = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.side = side_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.acc  = ~last_round;
					cmd.last = last_round;
					if (last_round) begin
						state_d = ST_DECIDE;
					end
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				if (!status.method) begin
					state_d = ST_RATIO_GO;
				end else if (status.hold) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_SQ_A;
				end
			end
			ST_SQ_A: begin
				cmd.sq_first = 1'b1;
				state_d      = ST_SQ_B;
			end
			ST_SQ_B: begin
				cmd.sq_add = 1'b1;
				state_d    = ST_SQRT_GO;
			end
			ST_SQRT_GO: begin
				cmd.sqrt_start = 1'b1;
				state_d        = ST_SQRT_WAIT;
			end
			ST_SQRT_WAIT: begin
				if (status.sqrt_done) begin
					state_d = ST_SCALE_GO;
				end
			end
			ST_SCALE_GO: begin
				cmd.scale_start = 1'b1;
				state_d         = ST_SCALE_WAIT;
			end
			ST_SCALE_WAIT: begin
				if (status.scale_done) begin
					cmd.store_mag = 1'b1;
					state_d       = side_q ? ST_RATIO_GO : ST_SQ_A;
				end
			end
			ST_RATIO_GO: begin
				cmd.ratio_start = 1'b1;
				state_d         = ST_RATIO_WAIT;
			end
			ST_RATIO_WAIT: begin
				if (status.div_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (load_out) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			round_q     <= '0;
			side_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				round_q <= last_round ? '0 : round_q + CNT_W'(1);
			end
			if (state_q == ST_DECIDE) begin
				side_q <= 1'b0;
			end else if (cmd.store_mag) begin
				side_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/inductor_steering_ratio_top.sv */
// Rounds are taken while the block is idle; only the last round of a group yields a result.
// Pair-ratio mode: after the last round, the result comes from the 15-step divider.
// Magnitude mode: two 19-step square roots in series, then the 15-step divider.
// A held ratio in magnitude mode skips the square roots and the divider.
// The output register lets the next group's rounds be taken while a result waits for transfer.
// arst_n clears the round count, channel sums, previous ratio and loads the register defaults.
module inductor_steering_ratio_top #(
	parameter int ROUNDS = 3
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  isr_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output isr_pkg::out_item_t             out_data,
	input  logic                           cfg_we,
	input  logic [isr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [isr_pkg::CFG_DATA_W-1:0] cfg_data
);

	import isr_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	isr_ctrl #(
		.ROUNDS(ROUNDS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	isr_datapath #(
		.ROUNDS(ROUNDS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

/* rtl/isr_checker.sv */
module isr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input isr_pkg::out_item_t out_data
);

	import isr_pkg::*;

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while stalled");

	// The two methods flag different things, never both.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.used_inner && out_data.held))
		else $error("inner selection and hold flagged together");

	// The magnitude clamp keeps the ratio off the most negative code.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.ratio != 16'sh8000)
		else $error("ratio outside clamp range");

endmodule

bind inductor_steering_ratio_top isr_checker u_isr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

/* verif/tb_inductor_steering_ratio_top.sv */
module tb_inductor_steering_ratio_top;
	timeunit 1ns;
	timeprecision 1ps;

	import isr_pkg::*;

	localparam int GROUP            = 3;
	localparam int SUM_TOP          = 200 * GROUP;
	localparam int SUM_BOTTOM       = 2 * GROUP;
	localparam int LEVEL_SCALE      = 2 * GROUP;
	localparam int DRAIN_CYCLES     = 150;
	localparam int HOLD_CYCLES      = 300;
	localparam int STALL_LIMIT      = 4000;
	localparam int PHASES           = 8;
	localparam int GROUPS_PER_PHASE = 50;

	typedef enum bit {STEP_ROUND, STEP_CFG} step_kind_e;

	typedef struct {
		step_kind_e  kind;
		cfg_reg_t    reg_sel;
		int unsigned value;
		in_item_t    item;
		bit          known;
		out_item_t   result;
	} dir_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_item_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Shadow copy of the register file, tracked as writes go out.
	bit        steer_method = 1'b0;
	bit [8:0]  edge_th      = EDGE_THRESHOLD_RST;
	bit [7:0]  win_lo       = MID_WINDOW_LOW_RST;
	bit [7:0]  win_hi       = MID_WINDOW_HIGH_RST;
	bit [7:0]  outer_lo     = OUTER_LOW_RST;
	bit [14:0] ratio_lim    = RATIO_LIMIT_RST;

	int unsigned round_cnt   = 0;
	int unsigned chan_acc[4] = '{0, 0, 0, 0};
	int          prev_ratio  = 0;

	out_item_t ratio_q[$];
	out_item_t want_res;
	dir_row_t  dir_table[$];
	in_item_t  grp_items[GROUP];
	int        fail_cnt    = 0;
	int        idle_cycles = 0;
	bit        gaps_on     = 1'b1;
	bit        stalls_on   = 1'b1;
	bit        hold_req    = 1'b0;

	inductor_steering_ratio_top #(.ROUNDS(GROUP)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int clip_ratio(int v);
		int lim;
		lim = int'(ratio_lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// Q0.15 difference over sum, truncated toward zero.
	function automatic int diff_over_sum(longint unsigned a, longint unsigned b);
		if (a >= b)
			return int'(((a - b) << 15) / (a + b));
		return -int'(((b - a) << 15) / (a + b));
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned x);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= x)
				root = trial;
		end
		return root;
	endfunction

	// Accumulates one round; returns 1 with the steering result on the last round of a group.
	function automatic bit steer_round(input in_item_t it, output out_item_t res);
		int unsigned smp[4];
		int unsigned lvl[4];
		int unsigned outer_s;
		int unsigned inner_s;
		int unsigned total;
		longint unsigned mag_l;
		longint unsigned mag_r;
		int r;
		smp[0] = it.outer_left;
		smp[1] = it.inner_left;
		smp[2] = it.inner_right;
		smp[3] = it.outer_right;
		res = '0;
		for (int i = 0; i < 4; i++)
			chan_acc[i] = (chan_acc[i] + smp[i] > SUM_TOP) ? SUM_TOP : chan_acc[i] + smp[i];
		round_cnt++;
		if (round_cnt < GROUP)
			return 1'b0;
		for (int i = 0; i < 4; i++) begin
			lvl[i] = (chan_acc[i] < SUM_BOTTOM) ? SUM_BOTTOM : chan_acc[i];
			chan_acc[i] = 0;
		end
		round_cnt = 0;
		if (!steer_method) begin
			outer_s = lvl[0] + lvl[3];
			inner_s = lvl[1] + lvl[2];
			if ((inner_s > win_lo * LEVEL_SCALE && inner_s < win_hi * LEVEL_SCALE) ||
			    outer_s < outer_lo * LEVEL_SCALE) begin
				r = diff_over_sum(lvl[1], lvl[2]);
				res.used_inner = 1'b1;
			end else begin
				r = diff_over_sum(lvl[0], lvl[3]);
			end
			r = clip_ratio(r);
		end else begin
			total = lvl[0] + lvl[1] + lvl[2] + lvl[3];
			if (total <= edge_th * LEVEL_SCALE) begin
				r = clip_ratio(prev_ratio);
				res.held = 1'b1;
			end else begin
				mag_l = floor_sqrt((64'(lvl[0]) * lvl[0] + 64'(lvl[1]) * lvl[1]) << 16)
					/ LEVEL_SCALE;
				mag_r = floor_sqrt((64'(lvl[3]) * lvl[3] + 64'(lvl[2]) * lvl[2]) << 16)
					/ LEVEL_SCALE;
				r = clip_ratio(diff_over_sum(mag_l, mag_r));
			end
		end
		prev_ratio = r;
		res.ratio = 16'(r);
		return 1'b1;
	endfunction

	function automatic dir_row_t round_row(bit [7:0] o_l, bit [7:0] i_l, bit [7:0] i_r,
			bit [7:0] o_r);
		dir_row_t row;
		row.kind    = STEP_ROUND;
		row.reg_sel = REG_METHOD;
		row.value   = 0;
		row.item    = '{outer_left: o_l, inner_left: i_l, inner_right: i_r, outer_right: o_r};
		row.known   = 1'b0;
		row.result  = '0;
		return row;
	endfunction

	function automatic dir_row_t known_row(bit [7:0] o_l, bit [7:0] i_l, bit [7:0] i_r,
			bit [7:0] o_r, int ratio, bit used, bit hld);
		dir_row_t row;
		row = round_row(o_l, i_l, i_r, o_r);
		row.known             = 1'b1;
		row.result.ratio      = 16'(ratio);
		row.result.used_inner = used;
		row.result.held       = hld;
		return row;
	endfunction

	function automatic dir_row_t write_row(cfg_reg_t sel, int unsigned val);
		dir_row_t row;
		row = round_row(8'd0, 8'd0, 8'd0, 8'd0);
		row.kind    = STEP_CFG;
		row.reg_sel = sel;
		row.value   = val;
		return row;
	endfunction

	function automatic void split_pair(int unsigned t, output bit [7:0] a, output bit [7:0] b);
		a = 8'($urandom_range(t > 255 ? t - 255 : 0, t > 255 ? 255 : t));
		b = 8'(t - a);
	endfunction

	// One group of rounds: random, scaled down, rail to rail, or placed on a threshold.
	function automatic void fill_group();
		int unsigned prof;
		int unsigned cap;
		int unsigned pick;
		int unsigned thr;
		int unsigned t;
		int unsigned pair;
		bit [7:0] a;
		bit [7:0] b;
		bit [7:0] c;
		bit [7:0] d;
		prof = $urandom_range(0, 9);
		case ($urandom_range(0, 3))
			0: cap = 2;
			1: cap = 15;
			2: cap = 40;
			default: cap = 90;
		endcase
		if (prof < 7) begin
			for (int r = 0; r < GROUP; r++) begin
				if (prof < 4) begin
					grp_items[r] = in_item_t'($urandom());
				end else if (prof < 6) begin
					grp_items[r].outer_left  = 8'($urandom_range(0, cap));
					grp_items[r].inner_left  = 8'($urandom_range(0, cap));
					grp_items[r].inner_right = 8'($urandom_range(0, cap));
					grp_items[r].outer_right = 8'($urandom_range(0, cap));
				end else begin
					grp_items[r].outer_left  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
					grp_items[r].inner_left  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
					grp_items[r].inner_right = $urandom_range(0, 1) ? 8'd255 : 8'd0;
					grp_items[r].outer_right = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				end
			end
		end else begin
			// Constant rounds make the group sum three times the round sum, so a round
			// pair sum of twice the threshold lands exactly on it.
			pick = $urandom_range(0, 3);
			case (pick)
				0: thr = win_lo;
				1: thr = win_hi;
				2: thr = outer_lo;
				default: thr = edge_th;
			endcase
			t = 2 * thr + $urandom_range(0, 2);
			t = (t > 0) ? t - 1 : 0;
			if (pick == 3) begin
				if (t > 1020)
					t = 1020;
				pair = $urandom_range(t > 510 ? t - 510 : 0, t > 510 ? 510 : t);
				split_pair(pair, a, b);
				split_pair(t - pair, c, d);
				grp_items[0] = '{outer_left: a, inner_left: b, inner_right: c, outer_right: d};
			end else begin
				if (t > 510)
					t = 510;
				split_pair(t, a, b);
				c = 8'($urandom_range(0, cap));
				d = 8'($urandom_range(0, cap));
				if (pick == 2)
					grp_items[0] = '{outer_left: a, inner_left: c, inner_right: d,
						outer_right: b};
				else
					grp_items[0] = '{outer_left: c, inner_left: a, inner_right: b,
						outer_right: d};
			end
			for (int r = 1; r < GROUP; r++)
				grp_items[r] = grp_items[0];
		end
	endfunction

	task automatic offer_round(input in_item_t it, input bit known, input out_item_t known_res);
		out_item_t pred;
		in_valid <= 1'b1;
		in_data  <= it;
		do
			@(posedge clk);
		while (!in_ready);
		if (steer_round(it, pred))
			ratio_q.push_back(known ? known_res : pred);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// A round that yields nothing leaves the block idle; the drain follows the last expected result.
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (ratio_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t sel, input int unsigned val);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= CFG_DATA_W'(val);
		case (sel)
			REG_METHOD:          steer_method = val[0];
			REG_EDGE_THRESHOLD:  edge_th      = val[8:0];
			REG_MID_WINDOW_LOW:  win_lo       = val[7:0];
			REG_MID_WINDOW_HIGH: win_hi       = val[7:0];
			REG_OUTER_LOW:       outer_lo     = val[7:0];
			REG_RATIO_LIMIT:     ratio_lim    = val[14:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(input bit m, input int unsigned e, input int unsigned lo,
			input int unsigned hi, input int unsigned ol, input int unsigned lim);
		wait_quiet();
		write_reg(REG_METHOD, m);
		write_reg(REG_EDGE_THRESHOLD, e);
		write_reg(REG_MID_WINDOW_LOW, lo);
		write_reg(REG_MID_WINDOW_HIGH, hi);
		write_reg(REG_OUTER_LOW, ol);
		write_reg(REG_RATIO_LIMIT, lim);
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (ratio_q.size() == 0) begin
				$error("unexpected result: ratio %0d", out_data.ratio);
				fail_cnt++;
			end else begin
				want_res = ratio_q.pop_front();
				if (out_data.ratio !== want_res.ratio) begin
					$error("ratio: expected %0d, got %0d", want_res.ratio, out_data.ratio);
					fail_cnt++;
				end
				if (out_data.used_inner !== want_res.used_inner) begin
					$error("used_inner: expected %0b, got %0b", want_res.used_inner,
						out_data.used_inner);
					fail_cnt++;
				end
				if (out_data.held !== want_res.held) begin
					$error("held: expected %0b, got %0b", want_res.held, out_data.held);
					fail_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("inductor_steering_ratio_top regression: fail");
			$finish;
		end
	end

	// Output side: random stall bursts, plus one long hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				out_ready <= 1'b1;
			end else if (stalls_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// All-zero rounds clamp every channel to the floor: outer sum low, inner pair used.
		repeat (2) dir_table.push_back(round_row(8'd0, 8'd0, 8'd0, 8'd0));
		dir_table.push_back(known_row(8'd0, 8'd0, 8'd0, 8'd0, 0, 1'b1, 1'b0));
		// Saturated sums, balanced.
		repeat (2) dir_table.push_back(round_row(8'd255, 8'd255, 8'd255, 8'd255));
		dir_table.push_back(known_row(8'd255, 8'd255, 8'd255, 8'd255, 0, 1'b0, 1'b0));
		// Fully one-sided outer pair hits the limit in both directions.
		repeat (2) dir_table.push_back(round_row(8'd255, 8'd255, 8'd255, 8'd0));
		dir_table.push_back(known_row(8'd255, 8'd255, 8'd255, 8'd0, 29491, 1'b0, 1'b0));
		repeat (2) dir_table.push_back(round_row(8'd0, 8'd255, 8'd255, 8'd255));
		dir_table.push_back(known_row(8'd0, 8'd255, 8'd255, 8'd255, -29491, 1'b0, 1'b0));
		// Inner sum inside its window.
		repeat (3) dir_table.push_back(round_row(8'd200, 8'd60, 8'd40, 8'd100));
		// Outer sum low while the inner sum is outside the window.
		repeat (3) dir_table.push_back(round_row(8'd10, 8'd200, 8'd20, 8'd10));
		// Magnitude mode with a weak signal keeps the previous ratio.
		dir_table.push_back(write_row(REG_METHOD, 1));
		repeat (3) dir_table.push_back(round_row(8'd0, 8'd0, 8'd0, 8'd0));
		// A zero limit forces the ratio to zero.
		dir_table.push_back(write_row(REG_RATIO_LIMIT, 0));
		repeat (2) dir_table.push_back(round_row(8'd255, 8'd255, 8'd0, 8'd0));
		dir_table.push_back(known_row(8'd255, 8'd255, 8'd0, 8'd0, 0, 1'b0, 1'b0));

		foreach (dir_table[k]) begin
			if (dir_table[k].kind == STEP_CFG) begin
				wait_quiet();
				write_reg(dir_table[k].reg_sel, dir_table[k].value);
			end else begin
				offer_round(dir_table[k].item, dir_table[k].known, dir_table[k].result);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			gaps_on   = (ph != PHASES - 1);
			stalls_on = (ph != PHASES - 1);
			case (ph)
				0: apply_settings(1'b0, EDGE_THRESHOLD_RST, MID_WINDOW_LOW_RST,
					MID_WINDOW_HIGH_RST, OUTER_LOW_RST, RATIO_LIMIT_RST);
				1: apply_settings(1'b1, EDGE_THRESHOLD_RST, MID_WINDOW_LOW_RST,
					MID_WINDOW_HIGH_RST, OUTER_LOW_RST, RATIO_LIMIT_RST);
				2: apply_settings(1'b0, 0, 0, 0, 0, 32767);
				3: apply_settings(1'b0, 400, 200, 200, 200, 32767);
				4: apply_settings(1'b1, 0, 0, 0, 0, 1);
				default: apply_settings($urandom_range(0, 1),
					$urandom_range(0, 1) ? $urandom_range(0, 80) : $urandom_range(0, 400),
					$urandom_range(0, 200), $urandom_range(0, 200), $urandom_range(0, 200),
					($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(0, 32767));
			endcase
			// The receiver holds off while rounds keep coming, so the block backs up.
			if (ph == 2)
				hold_req = 1'b1;
			for (int g = 0; g < GROUPS_PER_PHASE; g++) begin
				if (ph == 4 && g == GROUPS_PER_PHASE / 2) begin
					in_valid <= 1'b0;
					while (ratio_q.size() != 0)
						@(posedge clk);
				end
				fill_group();
				for (int r = 0; r < GROUP; r++)
					offer_round(grp_items[r], 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (ratio_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("inductor_steering_ratio_top regression: pass");
		else
			$display("inductor_steering_ratio_top regression: fail");
		$finish;
	end

endmodule

/* inductor_steering_ratio_top.f */
rtl/isr_pkg.sv
rtl/isr_div.sv
rtl/isr_sqrt.sv
rtl/isr_datapath.sv
rtl/isr_ctrl.sv
rtl/inductor_steering_ratio_top.sv
rtl/isr_checker.sv
verif/tb_inductor_steering_ratio_top.sv
